// File: rtl/sfa_pkg.sv
// Shared types and constants for the sensor fault annunciator.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfa_pkg;

    // Sensor count and field widths
    localparam int NUM_SENSORS = 4;
    localparam int FLAG_W      = 8;
    localparam int FLAGS_W     = 32;
    localparam int POS_W       = 4;
    localparam int SENSOR_MAP_W = 3 * POS_W;
    localparam int MAP_W       = 48;
    localparam int LED_W       = 16;
    localparam int TICK_W      = 24;

    // Padded widths so every sensor slice has a place, zero above the real field
    localparam int FLAG_PAD_W = (FLAG_W * NUM_SENSORS > FLAGS_W) ?
                                FLAG_W * NUM_SENSORS : FLAGS_W;
    localparam int MAP_PAD_W  = (SENSOR_MAP_W * NUM_SENSORS > MAP_W) ?
                                SENSOR_MAP_W * NUM_SENSORS : MAP_W;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // Opcodes
    localparam logic OP_STATUS = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_MAP   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMM_MASK = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT  = 4'd3;

    // Configuration reset values
    localparam logic [MAP_W-1:0]  RST_LED_MAP   = '0;
    localparam logic [FLAG_W-1:0] RST_COMM_MASK = 8'd1;
    localparam logic [TICK_W-1:0] RST_BEEP      = 24'd500;
    localparam logic [TICK_W-1:0] RST_CONSTANT  = 24'd20000;

    typedef logic [FLAG_W-1:0] t_flag_arr [NUM_SENSORS];

    typedef struct packed {
        logic               opcode;
        logic [FLAGS_W-1:0] all_fault_flags;
    } t_in_item;

    typedef struct packed {
        logic [LED_W-1:0] led_bits;
        logic             buzzer_on;
    } t_out_item;

    // Per-sensor classification passed from LED logic to the alarm timer
    typedef struct packed {
        logic [NUM_SENSORS-1:0] faulted;
        logic [NUM_SENSORS-1:0] comm;
    } t_sensor_stat;

endpackage

`default_nettype wire

// File: rtl/sfa_led.sv
// LED image builder: classifies each sensor and writes its red, yellow, green bits.
// Depends on sfa_pkg.
`default_nettype none

module sfa_led
    import sfa_pkg::*;
(
    input  wire t_flag_arr          i_flags,
    input  wire logic [MAP_W-1:0]   i_map,
    input  wire logic [FLAG_W-1:0]  i_comm_mask,
    input  wire logic [LED_W-1:0]   i_image,
    output logic [LED_W-1:0]        o_image,
    output t_sensor_stat            o_stat
);

    logic [MAP_PAD_W-1:0] map_pad;

    assign map_pad = MAP_PAD_W'(i_map);

    // Write red, yellow, green per sensor in order; later writes win
    always_comb begin
        logic [LED_W-1:0]        img;
        logic [SENSOR_MAP_W-1:0] pos;
        logic                    comm;
        logic                    fault;
        img = i_image;
        o_stat = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            pos   = map_pad[SENSOR_MAP_W*i +: SENSOR_MAP_W];
            fault = (i_flags[i] != '0);
            comm  = ((i_flags[i] & i_comm_mask) != '0);
            img[pos[POS_W-1:0]]         = fault && comm;
            img[pos[2*POS_W-1:POS_W]]   = fault && !comm;
            img[pos[3*POS_W-1:2*POS_W]] = !fault;
            o_stat.faulted[i] = fault;
            o_stat.comm[i]    = comm;
        end
        o_image = img;
    end

endmodule

`default_nettype wire

// File: rtl/sfa_alarm.sv
// Buzzer timer: previous flags, change detection, elapsed tick count and duration.
// Depends on sfa_pkg.
`default_nettype none

module sfa_alarm
    import sfa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_opcode,
    input  wire t_flag_arr         i_flags,
    input  wire t_sensor_stat      i_stat,
    input  wire logic [TICK_W-1:0] i_beep_ticks,
    input  wire logic [TICK_W-1:0] i_const_ticks,
    output logic                   o_buzzing_next
);

    logic [FLAG_W-1:0] r_prev [NUM_SENSORS];
    logic              r_buzzing;
    logic [TICK_W-1:0] r_elapsed;
    logic [TICK_W-1:0] r_duration;

    logic              n_buzzing;
    logic [TICK_W-1:0] n_elapsed;
    logic [TICK_W-1:0] n_duration;
    logic              changed;
    logic              all_missing;
    logic [TICK_W-1:0] cnt_inc;

    // Flag a faulted sensor whose flags moved since the last status transfer
    always_comb begin
        changed = 1'b0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (i_stat.faulted[i] && (r_prev[i] != i_flags[i])) begin
                changed = 1'b1;
            end
        end
    end

    assign all_missing = &(i_stat.faulted & i_stat.comm);
    assign cnt_inc = (r_elapsed < TICK_MAX) ? r_elapsed + 1'b1 : r_elapsed;

    // Start, restart or stop the buzzer
    always_comb begin
        n_buzzing  = r_buzzing;
        n_elapsed  = r_elapsed;
        n_duration = r_duration;
        if (i_opcode == OP_STATUS) begin
            if (all_missing) begin
                n_buzzing  = 1'b1;
                n_elapsed  = '0;
                n_duration = i_const_ticks;
            end else if (changed) begin
                n_buzzing  = 1'b1;
                n_elapsed  = '0;
                n_duration = i_beep_ticks;
            end
        end else begin
            n_elapsed = cnt_inc;
            if (r_buzzing && (cnt_inc >= r_duration)) begin
                n_buzzing = 1'b0;
            end
        end
    end

    assign o_buzzing_next = n_buzzing;

    // Commit state on each processed transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buzzing  <= 1'b0;
            r_elapsed  <= '0;
            r_duration <= '0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_prev[i] <= '0;
            end
        end else if (i_step) begin
            r_buzzing  <= n_buzzing;
            r_elapsed  <= n_elapsed;
            r_duration <= n_duration;
            if (i_opcode == OP_STATUS) begin
                for (int i = 0; i < NUM_SENSORS; i++) begin
                    r_prev[i] <= i_flags[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/sensor_fault_annunciator_unit.sv
// Sensor fault annunciator top level: config registers, input and result stages.
// Depends on sfa_pkg, sfa_led and sfa_alarm.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_data) carries a status
//    transfer (opcode 0, eight fault flags per sensor) or a tick (opcode 1).
//  - Every input transfer yields exactly one result on the output channel
//    (o_out_valid / i_out_ready / o_out_data): LED image and buzzer state.
//  - An accepted item sits in the input register, and its result is loaded into
//    the result register once the result register is free or draining.
//  - Throughput: one item per cycle while the receiver takes results; the input and
//    result registers form a two-deep pipe, so an item is taken while a result waits.
//  - When the receiver stalls, the result register holds, the input register
//    fills, and o_in_ready drops until the result is taken.
//  - Configuration writes (i_cfg_valid / o_cfg_ready) are always accepted;
//    write only when no transfer is in flight. Unknown indexes are ignored.
//  - Synchronous reset clears the pipe, LED image, timer and previous flags,
//    and loads the default register values (mask 1, beep 500, long 20000).
`default_nettype none

module sensor_fault_annunciator_unit
    import sfa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [MAP_W-1:0]     i_cfg_data
);

    logic [MAP_W-1:0]  r_led_map;
    logic [FLAG_W-1:0] r_comm_mask;
    logic [TICK_W-1:0] r_beep;
    logic [TICK_W-1:0] r_constant;

    logic              r_in_valid;
    t_in_item          r_in_item;
    logic              r_out_valid;
    t_out_item         r_out_item;
    logic [LED_W-1:0]  r_led_image;

    logic              step;
    logic              out_free;
    logic [FLAG_PAD_W-1:0] flags_pad;
    t_flag_arr         flags;
    t_sensor_stat      stat;
    logic [LED_W-1:0]  n_led_image;
    logic [LED_W-1:0]  led_calc;
    logic              buzz_next;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_map   <= RST_LED_MAP;
            r_comm_mask <= RST_COMM_MASK;
            r_beep      <= RST_BEEP;
            r_constant  <= RST_CONSTANT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LED_MAP:   r_led_map   <= i_cfg_data;
                CFG_COMM_MASK: r_comm_mask <= i_cfg_data[FLAG_W-1:0];
                CFG_BEEP:      r_beep      <= i_cfg_data[TICK_W-1:0];
                CFG_CONSTANT:  r_constant  <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipe control: process when the result register is free or draining
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // Split the flag word per sensor; sensors above the word read as zero
    assign flags_pad = FLAG_PAD_W'(r_in_item.all_fault_flags);

    always_comb begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
            flags[i] = flags_pad[FLAG_W*i +: FLAG_W];
        end
    end

    sfa_led u_led (
        .i_flags     (flags),
        .i_map       (r_led_map),
        .i_comm_mask (r_comm_mask),
        .i_image     (r_led_image),
        .o_image     (led_calc),
        .o_stat      (stat)
    );

    sfa_alarm u_alarm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_opcode       (r_in_item.opcode),
        .i_flags        (flags),
        .i_stat         (stat),
        .i_beep_ticks   (r_beep),
        .i_const_ticks  (r_constant),
        .o_buzzing_next (buzz_next)
    );

    // Ticks leave the LED image alone
    assign n_led_image = (r_in_item.opcode == OP_STATUS) ? led_calc : r_led_image;

    // LED image state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_image <= '0;
        end else if (step) begin
            r_led_image <= n_led_image;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item.led_bits  <= n_led_image;
            r_out_item.buzzer_on <= buzz_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

`default_nettype wire

// File: tb/sensor_fault_annunciator_unit_tb.sv
// Testbench for the sensor fault annunciator: LED image and buzzer timing checks.
// Depends on sfa_pkg and sensor_fault_annunciator_unit; a scoreboard class predicts
// each result and compares it with the block's output transfers.
`timescale 1ns / 1ps

import sfa_pkg::*;

// Predict LED image and buzzer state, hold expected results, compare transfers
class led_buzzer_scoreboard;
    logic [MAP_W-1:0]  pos_map;
    logic [FLAG_W-1:0] comm_mask;
    logic [TICK_W-1:0] beep_len;
    logic [TICK_W-1:0] long_len;
    logic [LED_W-1:0]  led_image;
    logic [FLAG_W-1:0] last_flags [NUM_SENSORS];
    bit                buzzing;
    logic [TICK_W-1:0] elapsed;
    logic [TICK_W-1:0] duration;
    t_out_item         expected_q [$];
    int                mismatches;

    function new();
        pos_map    = RST_LED_MAP;
        comm_mask  = RST_COMM_MASK;
        beep_len   = RST_BEEP;
        long_len   = RST_CONSTANT;
        led_image  = '0;
        buzzing    = 1'b0;
        elapsed    = '0;
        duration   = '0;
        mismatches = 0;
        foreach (last_flags[i]) last_flags[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAP_W-1:0] value);
        case (idx)
            CFG_LED_MAP:   pos_map   = value;
            CFG_COMM_MASK: comm_mask = value[FLAG_W-1:0];
            CFG_BEEP:      beep_len  = value[TICK_W-1:0];
            CFG_CONSTANT:  long_len  = value[TICK_W-1:0];
            default: ;
        endcase
    endfunction

    function void start_timer(logic [TICK_W-1:0] len);
        buzzing  = 1'b1;
        elapsed  = '0;
        duration = len;
    endfunction

    // Advance the predicted state by one accepted input transfer
    function void note_item(t_in_item item);
        logic [FLAG_W-1:0]       flags;
        logic [SENSOR_MAP_W-1:0] pos;
        bit                      comm;
        int                      missing;
        bit                      changed;
        t_out_item               want;
        if (item.opcode == OP_STATUS) begin
            missing = 0;
            changed = 1'b0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                // a slice above the field width shifts out to zero
                flags = FLAG_W'(item.all_fault_flags >> (FLAG_W * i));
                pos   = SENSOR_MAP_W'(pos_map >> (SENSOR_MAP_W * i));
                comm  = (flags & comm_mask) != 0;
                // red, then yellow, then green: a later write to one bit wins
                led_image[pos[0 +: POS_W]]       = (flags != 0) && comm;
                led_image[pos[POS_W +: POS_W]]   = (flags != 0) && !comm;
                led_image[pos[2*POS_W +: POS_W]] = (flags == 0);
                if (flags != 0) begin
                    if (comm) missing++;
                    if (last_flags[i] != flags) changed = 1'b1;
                end
                last_flags[i] = flags;
            end
            if (missing == NUM_SENSORS) start_timer(long_len);
            else if (changed) start_timer(beep_len);
        end else begin
            if (elapsed != TICK_MAX) elapsed++;
            if (buzzing && elapsed >= duration) buzzing = 1'b0;
        end
        want.led_bits  = led_image;
        want.buzzer_on = buzzing;
        expected_q.push_back(want);
    endfunction

    function void flag_error(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endfunction

    // Compare one output transfer with the oldest expectation
    function void check_result(t_out_item got);
        t_out_item want;
        if (expected_q.size() == 0) begin
            flag_error("unexpected result", '0, {got.led_bits, 15'd0, got.buzzer_on});
            return;
        end
        want = expected_q.pop_front();
        if (got.led_bits !== want.led_bits)
            flag_error("led_bits", want.led_bits, got.led_bits);
        if (got.buzzer_on !== want.buzzer_on)
            flag_error("buzzer_on", want.buzzer_on, got.buzzer_on);
    endfunction
endclass

module sensor_fault_annunciator_unit_tb;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'hF;
    localparam int TIMEOUT_NS = 2_000_000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS = 110;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_data;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MAP_W-1:0]     cfg_data;

    led_buzzer_scoreboard sb;
    int                   tx_idle_max;
    int                   rx_idle_max;
    logic [FLAG_W-1:0]    last_sent [NUM_SENSORS];

    sensor_fault_annunciator_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hold valid until the transfer, after a random gap
    task automatic send_item(input logic op, input logic [FLAGS_W-1:0] flags);
        int       gap;
        t_in_item item;
        gap = $urandom_range(0, tx_idle_max);
        item.opcode = op;
        item.all_fault_flags = flags;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        sb.note_item(item);
        if (op == OP_STATUS)
            for (int i = 0; i < NUM_SENSORS; i++)
                last_sent[i] = FLAG_W'(flags >> (FLAG_W * i));
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all registers, plus one unused index that must be ignored
    task automatic write_config(input logic [MAP_W-1:0] map, input logic [FLAG_W-1:0] mask,
                                input logic [TICK_W-1:0] beep, input logic [TICK_W-1:0] long_len);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [MAP_W-1:0]     val [5];
        idx = '{CFG_LED_MAP, CFG_COMM_MASK, CFG_BEEP, CFG_CONSTANT, CFG_UNUSED};
        val = '{map, MAP_W'(mask), MAP_W'(beep), MAP_W'(long_len),
                {16'($urandom), 32'($urandom)}};
        for (int k = 0; k < 5; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
            while (cfg_ready !== 1'b1) @(posedge clk);
            sb.write_reg(idx[k], val[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Flag byte that the current mask reads as a communication fault
    function automatic logic [FLAG_W-1:0] comm_byte();
        logic [FLAG_W-1:0] b;
        if (sb.comm_mask == 0) return FLAG_W'($urandom_range(1, 255));
        do b = FLAG_W'(1 << $urandom_range(0, FLAG_W - 1));
        while ((b & sb.comm_mask) == 0);
        return b | FLAG_W'($urandom);
    endfunction

    // Status word: mostly repeats, clears and comm faults, some random noise
    function automatic logic [FLAGS_W-1:0] make_flags();
        logic [FLAGS_W-1:0] word;
        logic [FLAG_W-1:0]  b;
        bit                 all_comm;
        int                 pick;
        word = '0;
        all_comm = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < NUM_SENSORS; i++) begin
            pick = $urandom_range(0, 9);
            if (all_comm) b = (pick < 5) ? last_sent[i] : comm_byte();
            else if (pick < 3) b = '0;
            else if (pick < 6) b = last_sent[i];
            else if (pick < 8) b = FLAG_W'($urandom);
            else b = comm_byte();
            // a repeated byte may no longer be a comm fault under a new mask
            if (all_comm && (b & sb.comm_mask) == 0) b = comm_byte();
            word |= FLAGS_W'(b) << (FLAG_W * i);
        end
        return word;
    endfunction

    // Accept results after a random stall and check each one
    initial begin
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            gap = $urandom_range(0, rx_idle_max);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            sb.check_result(out_data);
        end
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [MAP_W-1:0]  map;
        logic [FLAG_W-1:0] mask;
        logic [TICK_W-1:0] beep;
        logic [TICK_W-1:0] long_len;
        sb = new();
        foreach (last_sent[i]) last_sent[i] = '0;
        tx_idle_max = 0;
        rx_idle_max = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: all positions collide at bit 0
        send_item(OP_STATUS, 32'h0002_0001);
        send_item(OP_STATUS, 32'h0000_0000);
        send_item(OP_TICK,   32'hFFFF_FFFF);

        // Distinct positions, short durations: beep, expiry, long sound
        wait_for_results();
        map = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
            map |= MAP_W'({4'(3 * i + 2), 4'(3 * i + 1), 4'(3 * i)}) << (SENSOR_MAP_W * i);
        write_config(map, 8'h01, 24'd3, 24'd6);
        tx_idle_max = 9;
        rx_idle_max = 9;
        send_item(OP_STATUS, 32'h0000_0000);
        send_item(OP_STATUS, 32'h0000_0002);
        send_item(OP_TICK,   32'h0000_0000);
        send_item(OP_TICK,   32'h0000_0000);
        send_item(OP_TICK,   32'h0000_0000);
        send_item(OP_STATUS, 32'h0101_0101);
        // all comm faults and changed flags together: long duration wins
        send_item(OP_STATUS, 32'h0301_0101);
        send_item(OP_STATUS, 32'hFFFF_FFFF);
        send_item(OP_STATUS, 32'h0000_00FF);
        send_item(OP_STATUS, 32'h0000_00FF);
        send_item(OP_TICK,   32'h0000_0000);

        // Zero durations, empty mask, every position at the top bit
        wait_for_results();
        write_config({MAP_W{1'b1}}, 8'h00, 24'd0, 24'd0);
        tx_idle_max = 0;
        rx_idle_max = 0;
        send_item(OP_STATUS, 32'h0000_0080);
        send_item(OP_TICK,   32'h0000_0000);
        wait_for_results();
        write_config(map, 8'hFF, 24'd0, 24'd0);
        send_item(OP_STATUS, 32'h0101_0101);
        send_item(OP_TICK,   32'h0000_0000);
        send_item(OP_STATUS, 32'h0000_0000);

        // Random phases, each under its own settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_for_results();
            map      = {16'($urandom), 32'($urandom)};
            mask     = ($urandom_range(0, 2) == 0) ? 8'h01 : FLAG_W'($urandom);
            beep     = TICK_W'($urandom_range(0, 12));
            long_len = TICK_W'($urandom_range(0, 40));
            if (ph == 0) begin
                map      = {MAP_W{1'b1}};
                mask     = 8'hFF;
                beep     = TICK_MAX;
                long_len = TICK_MAX;
            end else if (ph == 1) begin
                mask = 8'h00;
                beep = '0;
            end
            write_config(map, mask, beep, long_len);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // alternate stretches with and without idling on each side
                if (n % 20 == 0) begin
                    tx_idle_max = 9 * $urandom_range(0, 1);
                    rx_idle_max = 9 * $urandom_range(0, 1);
                end
                if (ph == 2 && n == PHASE_ITEMS / 2) wait_for_results();
                if ($urandom_range(0, 99) < 45) send_item(OP_TICK, FLAGS_W'($urandom));
                else send_item(OP_STATUS, make_flags());
            end
        end

        wait_for_results();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// File: sensor_fault_annunciator_unit.f
rtl/sfa_pkg.sv
rtl/sfa_led.sv
rtl/sfa_alarm.sv
rtl/sensor_fault_annunciator_unit.sv
tb/sensor_fault_annunciator_unit_tb.sv
